// ----- rtl/note_dispenser_greedy_stock_unit_defines.svh -----
// Assertion helpers for the note dispenser.
// Both sample on clk and are off while rst_n is low.
`ifndef NOTE_DISPENSER_GREEDY_STOCK_UNIT_DEFINES_SVH
`define NOTE_DISPENSER_GREEDY_STOCK_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NDGS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("note dispenser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define NDGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("note dispenser: next-cycle check failed");

`endif

// ----- rtl/ndgs_pkg.sv -----
package ndgs_pkg;

  localparam int NUM_DENOMS  = 7;
  localparam int COUNT_WIDTH = 16;
  localparam int DEN_W       = $clog2(NUM_DENOMS);
  localparam int VAL_W       = 7;
  localparam int PROD_W      = COUNT_WIDTH + VAL_W;
  localparam int DATA_W      = 32;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 31;
  localparam int CMD_W       = 3;
  localparam int IDX_W       = 3;

  localparam logic [CMD_W-1:0] CMD_BALANCE  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_DEPOSIT  = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_WITHDRAW = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_REFILL   = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_VAULT    = CMD_W'(4);

  localparam logic [DATA_W-1:0] MIN_BALANCE_RST = DATA_W'(100);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NO_FUNDS  = 3'd2,
    ST_BELOW_MIN = 3'd3,
    ST_PARTIAL   = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_SIMPLE,
    KIND_ADD,
    KIND_WDRAW
  } kind_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic add_stock;
    logic add_credit;
    logic w_mul;
    logic w_quo;
    logic w_fix;
    logic w_done;
    logic vault_step;
    logic emit;
    logic den_clr;
    logic den_inc;
    logic den_load;
    logic acc_clr;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  wd_item;
    logic  den_last;
  } dp_stat_t;

  // note value per index, largest first
  function automatic logic [VAL_W-1:0] note_value(input logic [DEN_W-1:0] i);
    logic [VAL_W-1:0] v;
    case (i)
      DEN_W'(0): v = VAL_W'(100);
      DEN_W'(1): v = VAL_W'(50);
      DEN_W'(2): v = VAL_W'(20);
      DEN_W'(3): v = VAL_W'(10);
      DEN_W'(4): v = VAL_W'(5);
      DEN_W'(5): v = VAL_W'(2);
      default:   v = VAL_W'(1);
    endcase
    return v;
  endfunction

  // floor(2^RECIP_SHIFT / value), quotient estimate is at most one low
  function automatic logic [RECIP_W-1:0] note_recip(input logic [DEN_W-1:0] i);
    logic [RECIP_W-1:0] r;
    case (i)
      DEN_W'(0): r = RECIP_W'(21474836);
      DEN_W'(1): r = RECIP_W'(42949672);
      DEN_W'(2): r = RECIP_W'(107374182);
      DEN_W'(3): r = RECIP_W'(214748364);
      DEN_W'(4): r = RECIP_W'(429496729);
      DEN_W'(5): r = RECIP_W'(1073741824);
      default:   r = RECIP_W'(2147483648);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ndgs_datapath.sv -----
module ndgs_datapath
  import ndgs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [IDX_W-1:0]       in_denom_index,
  input  logic [COUNT_WIDTH-1:0] in_note_count_in,
  input  logic [DATA_W-1:0]      in_amount,
  input  logic                   cfg_we,
  input  logic [DATA_W-1:0]      cfg_wdata,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [DATA_W-1:0]      out_balance_out,
  output logic [DATA_W-1:0]      out_vault_total,
  output logic [IDX_W-1:0]       out_paid_index,
  output logic [COUNT_WIDTH-1:0] out_paid_count,
  output logic [DATA_W-1:0]      out_unpaid_remainder,
  output logic [NUM_DENOMS-1:0]  out_empty_mask,
  output logic                   out_last
);

  // latched item
  logic [CMD_W-1:0]       cmd_r;
  logic [IDX_W-1:0]       idx_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [DATA_W-1:0]      amt_r;

  // state
  logic [COUNT_WIDTH-1:0] stock_r [NUM_DENOMS];
  logic [COUNT_WIDTH-1:0] paid_r  [NUM_DENOMS];
  logic [DATA_W-1:0]      bal_r;
  logic [DATA_W-1:0]      min_r;

  // working registers
  logic [DEN_W-1:0]          den_r;
  logic [DATA_W-1:0]         rem_r;
  logic [DATA_W-1:0]         acc_r;
  logic [PROD_W-1:0]         prod_r;
  logic [PROD_W+RECIP_W-1:0] recip_r;
  logic [COUNT_WIDTH-1:0]    want_r;
  logic [PROD_W-1:0]         wv_r;
  logic                      div_r;
  logic                      sat_r;
  logic                      wd_item_r;
  status_t                   status_r;

  // output stage
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [DATA_W-1:0]      out_bal_r;
  logic [DATA_W-1:0]      out_vault_r;
  logic [IDX_W-1:0]       out_idx_r;
  logic [COUNT_WIDTH-1:0] out_cnt_r;
  logic [DATA_W-1:0]      out_rem_r;
  logic [NUM_DENOMS-1:0]  out_mask_r;
  logic                   out_last_r;

  // combinational
  logic [COUNT_WIDTH-1:0] stock_cur;
  logic [VAL_W-1:0]       val_cur;
  logic [PROD_W-1:0]      sv_prod;
  logic                   den_last;
  logic                   cmd_add;
  logic                   idx_ok;
  status_t                pre_code;
  kind_t                  kind;
  logic [COUNT_WIDTH-1:0] room;
  logic [COUNT_WIDTH-1:0] added;
  logic                   add_sat;
  logic [DATA_W:0]        credit_sum;
  logic                   cap_fits;
  logic [COUNT_WIDTH-1:0] want_sel;
  logic [DATA_W-1:0]      fix_rem;
  logic                   fix_up;
  logic [COUNT_WIDTH-1:0] want_fin;
  logic [DATA_W-1:0]      rem_fin;
  logic [DATA_W:0]        vault_sum;
  logic [NUM_DENOMS-1:0]  empty_mask;

  assign stock_cur = stock_r[den_r];
  assign val_cur   = note_value(den_r);
  assign sv_prod   = PROD_W'(stock_cur) * PROD_W'(val_cur);
  assign den_last  = (den_r == DEN_W'(NUM_DENOMS - 1));

  // decode and withdrawal checks
  assign cmd_add = (cmd_r == CMD_DEPOSIT) || (cmd_r == CMD_REFILL);
  assign idx_ok  = (idx_r < IDX_W'(NUM_DENOMS));

  always_comb begin
    pre_code = ST_INVALID;
    kind     = KIND_SIMPLE;
    if (cmd_r == CMD_WITHDRAW) begin
      if (amt_r == '0) begin
        pre_code = ST_INVALID;
      end else if (amt_r > bal_r) begin
        pre_code = ST_NO_FUNDS;
      end else if (bal_r < min_r) begin
        pre_code = ST_BELOW_MIN;
      end else begin
        pre_code = ST_OK;
        kind     = KIND_WDRAW;
      end
    end else if (cmd_add) begin
      if (idx_ok) begin
        pre_code = ST_OK;
        kind     = KIND_ADD;
      end
    end else if ((cmd_r == CMD_BALANCE) || (cmd_r == CMD_VAULT)) begin
      pre_code = ST_OK;
    end
  end

  // deposit / refill
  assign room       = ~stock_cur;
  assign add_sat    = (cnt_r > room);
  assign added      = add_sat ? room : cnt_r;
  assign credit_sum = {1'b0, bal_r} + (DATA_W + 1)'(prod_r);

  // greedy step: cap by stock, else reciprocal quotient plus one correction
  assign cap_fits = (DATA_W'(prod_r) <= rem_r);
  assign want_sel = cap_fits ? stock_cur : recip_r[RECIP_SHIFT +: COUNT_WIDTH];
  assign fix_rem  = rem_r - DATA_W'(wv_r);
  assign fix_up   = div_r && (fix_rem >= DATA_W'(val_cur));
  assign want_fin = want_r + COUNT_WIDTH'(fix_up);
  assign rem_fin  = fix_up ? (fix_rem - DATA_W'(val_cur)) : fix_rem;

  // saturating vault sum
  assign vault_sum = {1'b0, acc_r} + (DATA_W + 1)'(sv_prod);

  always_comb begin
    for (int i = 0; i < NUM_DENOMS; i++) begin
      empty_mask[i] = (stock_r[i] == '0);
    end
  end

  assign stat.kind     = kind;
  assign stat.wd_item  = wd_item_r;
  assign stat.den_last = den_last;

  // control state and stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
        stock_r[i] <= '0;
      end
      bal_r       <= '0;
      min_r       <= MIN_BALANCE_RST;
      den_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_we) begin
        min_r <= cfg_wdata;
      end
      if (cmd.den_load) begin
        den_r <= idx_r[DEN_W-1:0];
      end else if (cmd.den_clr) begin
        den_r <= '0;
      end else if (cmd.den_inc) begin
        den_r <= den_r + DEN_W'(1);
      end
      if (cmd.add_stock) begin
        stock_r[den_r] <= stock_cur + added;
      end else if (cmd.w_fix) begin
        stock_r[den_r] <= stock_cur - want_fin;
      end
      if (cmd.add_credit && (cmd_r == CMD_DEPOSIT)) begin
        bal_r <= credit_sum[DATA_W] ? '1 : credit_sum[DATA_W-1:0];
      end else if (cmd.w_done) begin
        bal_r <= bal_r - (amt_r - rem_r);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      idx_r <= in_denom_index;
      cnt_r <= in_note_count_in;
      amt_r <= in_amount;
    end
    if (cmd.decode) begin
      status_r  <= pre_code;
      wd_item_r <= (kind == KIND_WDRAW);
      rem_r     <= amt_r;
    end
    if (cmd.add_stock) begin
      sat_r  <= add_sat;
      prod_r <= PROD_W'(added) * PROD_W'(val_cur);
    end
    if (cmd.add_credit) begin
      status_r <= (sat_r || ((cmd_r == CMD_DEPOSIT) && credit_sum[DATA_W])) ?
                  ST_SATURATED : ST_OK;
    end
    if (cmd.w_mul) begin
      prod_r  <= sv_prod;
      recip_r <= (PROD_W + RECIP_W)'(rem_r[PROD_W-1:0]) *
                 (PROD_W + RECIP_W)'(note_recip(den_r));
    end
    if (cmd.w_quo) begin
      want_r <= want_sel;
      div_r  <= !cap_fits;
      wv_r   <= PROD_W'(want_sel) * PROD_W'(val_cur);
    end
    if (cmd.w_fix) begin
      paid_r[den_r] <= want_fin;
      rem_r         <= rem_fin;
    end
    if (cmd.w_done) begin
      status_r <= (rem_r != '0) ? ST_PARTIAL : ST_OK;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.vault_step) begin
      acc_r <= vault_sum[DATA_W] ? '1 : vault_sum[DATA_W-1:0];
    end
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_bal_r    <= bal_r;
      out_vault_r  <= acc_r;
      out_idx_r    <= wd_item_r ? IDX_W'(den_r) : '0;
      out_cnt_r    <= wd_item_r ? paid_r[den_r] : '0;
      out_rem_r    <= (wd_item_r && den_last) ? rem_r : '0;
      out_mask_r   <= empty_mask;
      out_last_r   <= !wd_item_r || den_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_balance_out      = out_bal_r;
  assign out_vault_total      = out_vault_r;
  assign out_paid_index       = out_idx_r;
  assign out_paid_count       = out_cnt_r;
  assign out_unpaid_remainder = out_rem_r;
  assign out_empty_mask       = out_mask_r;
  assign out_last             = out_last_r;

endmodule

// ----- rtl/ndgs_ctrl.sv -----
module ndgs_ctrl
  import ndgs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD1,
    S_ADD2,
    S_WMUL,
    S_WQUO,
    S_WFIX,
    S_WDONE,
    S_VAULT,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && !busy_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode  = 1'b1;
        cmd.acc_clr = 1'b1;
        unique case (stat.kind)
          KIND_ADD: begin
            cmd.den_load = 1'b1;
            state_nxt    = S_ADD1;
          end
          KIND_WDRAW: begin
            cmd.den_clr = 1'b1;
            state_nxt   = S_WMUL;
          end
          default: begin
            cmd.den_clr = 1'b1;
            state_nxt   = S_VAULT;
          end
        endcase
      end
      S_ADD1: begin
        cmd.add_stock = 1'b1;
        state_nxt     = S_ADD2;
      end
      S_ADD2: begin
        cmd.add_credit = 1'b1;
        cmd.den_clr    = 1'b1;
        cmd.acc_clr    = 1'b1;
        state_nxt      = S_VAULT;
      end
      S_WMUL: begin
        cmd.w_mul = 1'b1;
        state_nxt = S_WQUO;
      end
      S_WQUO: begin
        cmd.w_quo = 1'b1;
        state_nxt = S_WFIX;
      end
      S_WFIX: begin
        cmd.w_fix = 1'b1;
        if (stat.den_last) begin
          state_nxt = S_WDONE;
        end else begin
          cmd.den_inc = 1'b1;
          state_nxt   = S_WMUL;
        end
      end
      S_WDONE: begin
        cmd.w_done  = 1'b1;
        cmd.den_clr = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_VAULT;
      end
      S_VAULT: begin
        cmd.vault_step = 1'b1;
        if (stat.den_last) begin
          cmd.den_clr = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.den_inc = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (!stat.wd_item || stat.den_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.den_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ----- rtl/note_dispenser_greedy_stock_unit.sv -----
// Results of one item come back to back; a new item is taken only once the last one
//   is through, as start is accepted only while busy is low.
// The withdrawal walks the seven note values one after another through one shared
//   multiply-and-correct step.
// Reset: synchronous, active low; stock and balance clear, min_balance returns to 100.
// Results are a one-cycle strobe on out_valid; the receiver cannot stall.
`include "note_dispenser_greedy_stock_unit_defines.svh"

// Note dispenser with a limited note stock and one account balance.
//
// Flow of one item:
//   accept  - start taken while busy is low, fields latched
//   decode  - command sorted; withdrawal checks (zero amount, funds,
//             minimum balance) made against the latched balance
//   add     - stock capped at full scale, then credit with
//             a saturating add (deposit only)
//   payout  - per note value, largest first:
//               mul : stock*value and remainder*reciprocal
//               quo : take the whole stock if it fits, else the
//                     reciprocal quotient (never more than one low)
//               fix : one compare-and-subtract correction, stock and
//                     remainder updated, notes paid recorded
//             then the balance is debited by what was actually paid
//   vault   - sweep over the seven note values summing stock*value, saturating
//   emit    - one item for every other command, seven for a paid withdrawal
//             with last on the final one
// Config writes to min_balance are taken in any cycle.
module note_dispenser_greedy_stock_unit
  import ndgs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [IDX_W-1:0]       in_denom_index,
  input  logic [COUNT_WIDTH-1:0] in_note_count_in,
  input  logic [DATA_W-1:0]      in_amount,
  input  logic                   cfg_we,
  input  logic [DATA_W-1:0]      cfg_wdata,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [DATA_W-1:0]      out_balance_out,
  output logic [DATA_W-1:0]      out_vault_total,
  output logic [IDX_W-1:0]       out_paid_index,
  output logic [COUNT_WIDTH-1:0] out_paid_count,
  output logic [DATA_W-1:0]      out_unpaid_remainder,
  output logic [NUM_DENOMS-1:0]  out_empty_mask,
  output logic                   out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  ndgs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // stock, balance, payout arithmetic and output register
  ndgs_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_command           (in_command),
    .in_denom_index       (in_denom_index),
    .in_note_count_in     (in_note_count_in),
    .in_amount            (in_amount),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_balance_out      (out_balance_out),
    .out_vault_total      (out_vault_total),
    .out_paid_index       (out_paid_index),
    .out_paid_count       (out_paid_count),
    .out_unpaid_remainder (out_unpaid_remainder),
    .out_empty_mask       (out_empty_mask),
    .out_last             (out_last)
  );

  // an accepted item always makes the block busy
  `NDGS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // results only come out of work that was in progress
  `NDGS_ASSERT_NOW(a_out_from_busy, out_valid, $past(busy))
  // payout items run back to back up to the last one
  `NDGS_ASSERT_NEXT(a_burst_cont, out_valid && !out_last, out_valid)
  // nothing follows the last item directly
  `NDGS_ASSERT_NEXT(a_last_gap, out_valid && out_last, !out_valid)

endmodule
